FILE: rtl/gcns_pkg.sv
`timescale 1ns / 1ps
// gcns_pkg: shared widths and the command/status structs of the chromatic number search
// used by gcns_ctrl, gcns_dp and graph_chromatic_number_search_unit

package gcns_pkg;

    localparam int ROW_W   = 8;
    localparam int ROWIX_W = 3;
    localparam int COLOR_W = 4;
    localparam int COUNT_W = 4;

    typedef struct packed {
        logic wr_row;
        logic start;
        logic next_k;
        logic step;
        logic load_res;
        logic res_zero;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic self_loop;
        logic at_end;
        logic exhausted;
        logic k_last;
    } t_status;

endpackage

FILE: rtl/gcns_ctrl.sv
`timescale 1ns / 1ps
// gcns_ctrl: sequencer for row loading, backtracking search and result hand-off
// depends on gcns_pkg

module gcns_ctrl
    import gcns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last_row,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall,
    output logic    o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_found, n_found;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_row = 1'b1;
                    if (i_last_row) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.n_zero || i_status.self_loop) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.at_end) begin
                    n_found = 1'b1;
                    n_state = S_FINISH;
                end else if (i_status.exhausted) begin
                    if (i_status.k_last) begin
                        n_found = 1'b0;
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.next_k = 1'b1;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_zero = !r_found;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: rtl/gcns_dp.sv
`timescale 1ns / 1ps
// gcns_dp: adjacency rows, vertex count register, colouring stack and clash check
// depends on gcns_pkg

module gcns_dp
    import gcns_pkg::*;
#(
    parameter int NUM_V = 8
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic [ROWIX_W-1:0] i_row_index,
    input  logic [ROW_W-1:0]   i_row_bits,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [COLOR_W-1:0] o_chromatic
);

    localparam int VW = $clog2(NUM_V + 1);
    localparam int AW = (NUM_V > 1) ? $clog2(NUM_V) : 1;

    logic [ROW_W-1:0]   r_adj [NUM_V];
    logic [COLOR_W-1:0] r_col [NUM_V];
    logic [COUNT_W-1:0] r_vcount;
    logic [VW-1:0]      r_v;
    logic [COLOR_W-1:0] r_cand;
    logic [COLOR_W-1:0] r_k;
    logic [COLOR_W-1:0] r_result;

    logic [COUNT_W-1:0] w_n;
    logic [AW-1:0]      w_vi;
    logic [AW-1:0]      w_pi;
    logic [ROWIX_W-1:0] w_vb;
    logic [ROW_W-1:0]   w_vrow;
    logic [NUM_V-1:0]   w_clash_u;
    logic [NUM_V-1:0]   w_loop_u;
    logic               w_clash;
    logic               w_over;

    assign w_n    = (r_vcount > COUNT_W'(NUM_V)) ? COUNT_W'(NUM_V) : r_vcount;
    assign w_vi   = AW'(r_v);
    assign w_pi   = AW'(r_v - VW'(1));
    assign w_vb   = ROWIX_W'(r_v);
    assign w_vrow = r_adj[w_vi];
    assign w_over = (r_cand > r_k);

    always_comb begin
        for (int u = 0; u < NUM_V; u++) begin
            w_clash_u[u] = (VW'(u) < r_v) && (r_col[u] == r_cand) &&
                           (r_adj[u][w_vb] || w_vrow[u]);
            w_loop_u[u]  = (COUNT_W'(u) < w_n) && r_adj[u][u];
        end
    end

    assign w_clash = |w_clash_u;

    assign o_status.n_zero    = (w_n == '0);
    assign o_status.self_loop = |w_loop_u;
    assign o_status.at_end    = (COUNT_W'(r_v) == w_n);
    assign o_status.exhausted = w_over && (r_v == '0);
    assign o_status.k_last    = (r_k == w_n);

    // row store, colouring stack and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_row && (COUNT_W'(i_row_index) < COUNT_W'(NUM_V))) begin
            r_adj[AW'(i_row_index)] <= i_row_bits;
        end
        if (i_cmd.start || i_cmd.next_k) begin
            for (int u = 0; u < NUM_V; u++) begin
                r_col[u] <= '0;
            end
        end else if (i_cmd.step) begin
            if (w_over) begin
                r_col[w_pi] <= '0;
            end else if (!w_clash) begin
                r_col[w_vi] <= r_cand;
            end
        end
        if (i_cmd.load_res) begin
            r_result <= i_cmd.res_zero ? '0 : r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_v      <= '0;
            r_cand   <= '0;
            r_k      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_k    <= COLOR_W'(1);
                r_v    <= '0;
                r_cand <= COLOR_W'(1);
            end else if (i_cmd.next_k) begin
                r_k    <= r_k + COLOR_W'(1);
                r_v    <= '0;
                r_cand <= COLOR_W'(1);
            end else if (i_cmd.step) begin
                if (w_over) begin
                    // backtrack: resume the previous vertex at its next colour
                    r_v    <= r_v - VW'(1);
                    r_cand <= r_col[w_pi] + COLOR_W'(1);
                end else if (w_clash) begin
                    r_cand <= r_cand + COLOR_W'(1);
                end else begin
                    r_v    <= r_v + VW'(1);
                    r_cand <= COLOR_W'(1);
                end
            end
        end
    end

    assign o_chromatic = r_result;

endmodule

FILE: rtl/graph_chromatic_number_search_unit.sv
`timescale 1ns / 1ps
// graph_chromatic_number_search_unit: top level, brute force chromatic number search
// depends on gcns_pkg, gcns_ctrl and gcns_dp
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_row_index, i_row_bits, i_last_row
// result    out        o_valid / i_stall    o_chromatic
// config    in         i_cfg_we             i_cfg_data (vertex count)
//
// a row item without last_row is stored and the input stays ready for the next row
// a last row leads to a check that gives 0 for no vertices or a self-loop, else to one
// backtracking step per cycle in the datapath for colour limits from 1 upward until a
// colouring fits; the result is then handed off once the output slot is free
// the result register lets the next rows load while a result waits on i_stall
// synchronous active-low reset clears the vertex count and all control state

module graph_chromatic_number_search_unit
    import gcns_pkg::*;
#(
    parameter int MAX_VERTICES = 8
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [ROWIX_W-1:0] i_row_index,
    input  logic [ROW_W-1:0]   i_row_bits,
    input  logic               i_last_row,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COLOR_W-1:0] o_chromatic
);

    localparam int NV = (MAX_VERTICES > ROW_W) ? ROW_W : MAX_VERTICES;

    t_cmd    w_cmd;
    t_status w_status;

    gcns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_row (i_last_row),
        .i_stall    (i_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall),
        .o_valid    (o_valid)
    );

    gcns_dp #(
        .NUM_V (NV)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_chromatic (o_chromatic)
    );

    a_last_row_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_row) |=> o_stall)
        else $error("input taken while search starts");

    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a search");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chromatic <= COLOR_W'(NV)))
        else $error("result above vertex limit");

endmodule

FILE: tb/graph_chromatic_number_search_unit_tb.sv
`timescale 1ns / 1ps
// graph_chromatic_number_search_unit_tb: self-checking testbench for the chromatic number search
// drives adjacency rows and vertex counts, predicts every result with its own backtracking search
// depends on gcns_pkg and graph_chromatic_number_search_unit

module graph_chromatic_number_search_unit_tb;
    import gcns_pkg::*;

    localparam int MAX_V = 8;

    typedef struct packed {
        logic [ROWIX_W-1:0] index;
        logic [ROW_W-1:0]   bits;
        logic               last;
    } t_row_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ROWIX_W-1:0] i_row_index = '0;
    logic [ROW_W-1:0]   i_row_bits = '0;
    logic               i_last_row = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [COLOR_W-1:0] o_chromatic;

    t_row_item          row_queue[$];
    t_row_item          next_row;
    logic [COLOR_W-1:0] expected_colours[$];
    logic [COLOR_W-1:0] wanted;
    logic [ROW_W-1:0]   graph_rows[MAX_V];
    logic [COUNT_W-1:0] vertex_limit = '0;
    int                 queued_rows = 0;
    int                 accepted_rows = 0;
    int                 errors = 0;
    bit                 calm = 1'b0;

    graph_chromatic_number_search_unit #(
        .MAX_VERTICES(MAX_V)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_last_row  (i_last_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_chromatic (o_chromatic)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    // least colour limit for which a proper colouring of vertices 0..n-1 exists, or 0 on a self-loop or when n is 0
    function automatic logic [COLOR_W-1:0] least_colours(input int n);
        int col[MAX_V];
        int v;
        int k;
        int u;
        int i;
        bit clash;
        bit done;
        bit found;
        for (i = 0; i < n; i++) begin
            if (graph_rows[i][i]) begin
                return '0;
            end
        end
        for (k = 1; k <= n; k++) begin
            for (i = 0; i < MAX_V; i++) begin
                col[i] = 0;
            end
            v = 0;
            done = 1'b0;
            found = 1'b0;
            while (!done) begin
                col[v]++;
                if (col[v] > k) begin
                    col[v] = 0;
                    if (v == 0) begin
                        done = 1'b1;
                    end else begin
                        v--;
                    end
                end else begin
                    clash = 1'b0;
                    for (u = 0; u < v; u++) begin
                        if (col[u] == col[v] && (graph_rows[u][v] || graph_rows[v][u])) begin
                            clash = 1'b1;
                        end
                    end
                    if (!clash) begin
                        if (v == n - 1) begin
                            found = 1'b1;
                            done = 1'b1;
                        end else begin
                            v++;
                        end
                    end
                end
            end
            if (found) begin
                return COLOR_W'(k);
            end
        end
        return '0;
    endfunction

    // row driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (row_queue.size() > 0 && !take_break()) begin
                next_row = row_queue.pop_front();
                i_valid <= 1'b1;
                i_row_index <= next_row.index;
                i_row_bits <= next_row.bits;
                i_last_row <= next_row.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= take_break();
        end
    end

    // predictor and result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_limit = '0;
        end else begin
            if (i_cfg_we) begin
                vertex_limit = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                graph_rows[i_row_index] = i_row_bits;
                accepted_rows++;
                if (i_last_row) begin
                    expected_colours = {expected_colours,
                        least_colours((vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit))};
                end
            end
            if (o_valid && !i_stall) begin
                if (expected_colours.size() == 0) begin
                    $error("chromatic: unexpected result, expected none, actual %0d",
                           o_chromatic);
                    errors++;
                end else begin
                    wanted = expected_colours.pop_front();
                    if (o_chromatic !== wanted) begin
                        $error("chromatic mismatch: expected %0d, actual %0d",
                               wanted, o_chromatic);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_row(input int index, input logic [ROW_W-1:0] bits, input bit last);
        t_row_item item;
        item.index = ROWIX_W'(index);
        item.bits = bits;
        item.last = last;
        row_queue = {row_queue, item};
        queued_rows++;
    endtask

    task automatic wait_drained();
        while (queued_rows != accepted_rows || expected_colours.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input int count);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= COUNT_W'(count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int i;
        int j;
        int n;
        int graphs;
        int per_phase;
        int rows;
        int start;
        int density;
        int pick;
        int random_rows;
        int graphs_done;
        logic [ROW_W-1:0] bits;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // complete graph on eight vertices, every row written
        write_vertex_count(8);
        for (i = 0; i < MAX_V; i++) begin
            push_row(i, ~(ROW_W'(1) << i), i == MAX_V - 1);
        end
        // self-loop, then a complete graph on four vertices
        write_vertex_count(4);
        push_row(0, 8'h01, 1'b1);
        push_row(0, 8'hFE, 1'b1);
        // empty vertex set
        write_vertex_count(0);
        push_row(7, 8'hFF, 1'b1);
        // count above the row width saturates
        write_vertex_count(15);
        push_row(3, 8'hF7, 1'b1);
        push_row(7, 8'h00, 1'b1);
        // single vertex, bits beyond the count ignored
        write_vertex_count(1);
        push_row(0, 8'hFE, 1'b1);
        write_vertex_count(2);
        push_row(0, 8'h00, 1'b0);
        push_row(1, 8'h00, 1'b1);
        push_row(1, 8'h01, 1'b1);
        write_vertex_count(3);
        push_row(2, 8'h03, 1'b1);

        random_rows = 0;
        graphs_done = 0;
        while (random_rows < 80 || graphs_done < 16) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                n = 0;
            end else if (pick < 70) begin
                n = $urandom_range(1, 5);
            end else if (pick < 85) begin
                n = $urandom_range(6, 7);
            end else if (pick < 93) begin
                n = 8;
            end else begin
                n = $urandom_range(9, 15);
            end
            write_vertex_count(n);
            per_phase = $urandom_range(1, 4);
            for (graphs = 0; graphs < per_phase; graphs++) begin
                calm = (graphs_done >= 8 && graphs_done < 16);
                density = $urandom_range(10, 100);
                start = $urandom_range(MAX_V - 1);
                rows = (n >= 7) ? MAX_V : $urandom_range(1, 4);
                for (j = 0; j < rows; j++) begin
                    i = (n >= 7) ? (start + j) % MAX_V : $urandom_range(MAX_V - 1);
                    bits = '0;
                    for (pick = 0; pick < ROW_W; pick++) begin
                        bits[pick] = ($urandom_range(99) < density);
                    end
                    bits[i] = ($urandom_range(99) < 8);
                    // a few sequences stop short of their last row
                    push_row(i, bits, (j == rows - 1) && ($urandom_range(99) >= 5));
                    random_rows++;
                end
                graphs_done++;
                wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
